/* hdl/sfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants for the sepia / fade / brightness pixel filter.
// ----------------------------------------------------------------------------
package sfb_pkg;

    // APB register map: register i at byte address 4*i
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_VINTAGE = 1'b0;
    localparam logic REG_BRIGHT  = 1'b1;

    localparam logic [6:0] BRIGHT_RESET   = 7'd50;
    localparam logic [6:0] BRIGHT_MAX     = 7'd100;
    localparam logic [6:0] BRIGHT_NEUTRAL = 7'd50;

    // Sepia mix, coefficients scaled by 1000: [out channel][in channel]
    localparam logic [9:0] SEPIA_K [3][3] = '{
        '{10'd393, 10'd769, 10'd189},
        '{10'd349, 10'd686, 10'd168},
        '{10'd272, 10'd534, 10'd131}
    };

    // floor(x/1000) = (x*DIV1000_M) >> DIV1000_SH, exact for x < 493999
    localparam logic [18:0] DIV1000_M  = 19'd268436;
    localparam int          DIV1000_SH = 28;
    // floor(x/100) = (x*5243) >> 19, exact for x < 43699
    localparam logic [12:0] DIV100_M   = 13'd5243;
    // floor(x/10) = (x*52429) >> 19, exact for x < 2^18
    localparam logic [15:0] DIV10_M    = 16'd52429;

    localparam logic [7:0] CH_MAX = 8'd255;
    localparam logic [3:0] FADE_R_ADD = 4'd10;
    localparam logic [3:0] FADE_G_ADD = 4'd5;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } result_t;

    // Per-stage sideband that travels with each transaction
    typedef struct packed {
        logic              valid;
        logic              vintage;
        logic signed [7:0] offset;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
    } ctl_t;

endpackage

/* hdl/sfb_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_cfg
// APB register file; also holds the brightness offset, worked out on write.
// ----------------------------------------------------------------------------
module sfb_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic                          vintage,
    output logic signed [7:0]             offset
);
    import sfb_pkg::*;

    logic              vintage_reg;
    logic [6:0]        bright_reg;
    logic signed [7:0] offset_reg;
    logic signed [7:0] offset_next;
    logic              wr_en;
    logic [6:0]        bsat;
    logic [5:0]        mag;
    logic [13:0]       scaled;
    logic [26:0]       prod;
    logic [7:0]        qmag;

    assign pready = 1'b1;
    // registers sit on word boundaries only
    assign wr_en  = psel & penable & pwrite & (paddr[1:0] == 2'b00);

    // offset = trunc((min(b,100)-50)*255/100)
    always_comb
    begin
        bsat   = (pwdata[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[6:0];
        mag    = (bsat >= BRIGHT_NEUTRAL) ? 6'(bsat - BRIGHT_NEUTRAL)
                                          : 6'(BRIGHT_NEUTRAL - bsat);
        scaled = (14'(mag) << 8) - 14'(mag);
        prod   = 27'(scaled) * 27'(DIV100_M);
        qmag   = {1'b0, prod[25:19]};
        offset_next = (bsat >= BRIGHT_NEUTRAL) ? $signed(qmag) : -$signed(qmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vintage_reg <= 1'b0;
            bright_reg  <= BRIGHT_RESET;
            offset_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_VINTAGE:
                begin
                    vintage_reg <= pwdata[0];
                end
                REG_BRIGHT:
                begin
                    bright_reg <= pwdata[6:0];
                    offset_reg <= offset_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_VINTAGE: prdata = {31'b0, vintage_reg};
            REG_BRIGHT:  prdata = {25'b0, bright_reg};
            default:     prdata = '0;
        endcase
    end

    assign vintage = vintage_reg;
    assign offset  = offset_reg;

endmodule

/* hdl/sfb_sepia.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_sepia
// Two stages: 3x3 sepia mix sums, then divide by 1000 and clamp.
// ----------------------------------------------------------------------------
module sfb_sepia (
    input  logic          clk,
    input  logic          rst_n,
    input  sfb_pkg::ctl_t ctl_in,
    output sfb_pkg::ctl_t ctl_out,
    output logic [7:0]    sep_r,
    output logic [7:0]    sep_g,
    output logic [7:0]    sep_b
);
    import sfb_pkg::*;

    ctl_t        ctl_a_reg;
    ctl_t        ctl_b_reg;
    logic [18:0] sum_reg  [3];
    logic [18:0] sum_next [3];
    logic [7:0]  sep_reg  [3];
    logic [7:0]  sep_next [3];
    logic [37:0] prod     [3];
    logic [9:0]  quot     [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = 19'(SEPIA_K[c][0]) * 19'(ctl_in.red)
                        + 19'(SEPIA_K[c][1]) * 19'(ctl_in.green)
                        + 19'(SEPIA_K[c][2]) * 19'(ctl_in.blue);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod[c]     = 38'(sum_reg[c]) * 38'(DIV1000_M);
            quot[c]     = prod[c][DIV1000_SH+9:DIV1000_SH];
            sep_next[c] = (quot[c] > 10'(CH_MAX)) ? CH_MAX : quot[c][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        sep_reg <= sep_next;
    end

    assign ctl_out = ctl_b_reg;
    assign sep_r   = sep_reg[0];
    assign sep_g   = sep_reg[1];
    assign sep_b   = sep_reg[2];

endmodule

/* hdl/sfb_fade.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_fade
// Two stages: scale by fade numerators, then reciprocal divide, bias, clamp.
// ----------------------------------------------------------------------------
module sfb_fade (
    input  logic          clk,
    input  logic          rst_n,
    input  sfb_pkg::ctl_t ctl_in,
    input  logic [7:0]    sep_r,
    input  logic [7:0]    sep_g,
    input  logic [7:0]    sep_b,
    output sfb_pkg::ctl_t ctl_out,
    output logic [7:0]    fade_r,
    output logic [7:0]    fade_g,
    output logic [7:0]    fade_b
);
    import sfb_pkg::*;

    ctl_t        ctl_a_reg;
    ctl_t        ctl_b_reg;
    logic [14:0] r95_reg;
    logic [11:0] g9_reg;
    logic [9:0]  b3_reg;
    logic [27:0] r_prod;
    logic [27:0] g_prod;
    logic [9:0]  r_sum;
    logic [9:0]  g_sum;
    logic [7:0]  fade_r_reg;
    logic [7:0]  fade_g_reg;
    logic [7:0]  fade_b_reg;
    logic [7:0]  fade_r_next;
    logic [7:0]  fade_g_next;
    logic [7:0]  fade_b_next;

    always_comb
    begin
        // r*95/100 + 10, g*9/10 + 5, b*3/4
        r_prod = 28'(r95_reg) * 28'(DIV100_M);
        g_prod = 28'(g9_reg) * 28'(DIV10_M);
        r_sum  = 10'(r_prod[27:19]) + 10'(FADE_R_ADD);
        g_sum  = 10'(g_prod[27:19]) + 10'(FADE_G_ADD);
        fade_r_next = (r_sum > 10'(CH_MAX)) ? CH_MAX : r_sum[7:0];
        fade_g_next = (g_sum > 10'(CH_MAX)) ? CH_MAX : g_sum[7:0];
        fade_b_next = b3_reg[9:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r95_reg    <= 15'(sep_r) * 15'd95;
        g9_reg     <= 12'(sep_g) * 12'd9;
        b3_reg     <= 10'(sep_b) * 10'd3;
        fade_r_reg <= fade_r_next;
        fade_g_reg <= fade_g_next;
        fade_b_reg <= fade_b_next;
    end

    assign ctl_out = ctl_b_reg;
    assign fade_r  = fade_r_reg;
    assign fade_g  = fade_g_reg;
    assign fade_b  = fade_b_reg;

endmodule

/* hdl/sfb_bright.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_bright
// Final stage: vintage bypass select, signed brightness offset, clamp.
// ----------------------------------------------------------------------------
module sfb_bright (
    input  logic             clk,
    input  logic             rst_n,
    input  sfb_pkg::ctl_t    ctl_in,
    input  logic [7:0]       fade_r,
    input  logic [7:0]       fade_g,
    input  logic [7:0]       fade_b,
    output logic             done,
    output sfb_pkg::result_t result
);
    import sfb_pkg::*;

    logic              done_reg;
    result_t           result_reg;
    result_t           result_next;
    logic [7:0]        chan  [3];
    logic [7:0]        outc  [3];
    logic signed [9:0] total [3];

    always_comb
    begin
        chan[0] = ctl_in.vintage ? fade_r : ctl_in.red;
        chan[1] = ctl_in.vintage ? fade_g : ctl_in.green;
        chan[2] = ctl_in.vintage ? fade_b : ctl_in.blue;
        for (int c = 0; c < 3; c++)
        begin
            total[c] = $signed({2'b00, chan[c]}) + 10'(ctl_in.offset);
            if (total[c] < 0)
            begin
                outc[c] = '0;
            end
            else if (total[c] > $signed(10'(CH_MAX)))
            begin
                outc[c] = CH_MAX;
            end
            else
            begin
                outc[c] = total[c][7:0];
            end
        end
        result_next.red_out   = outc[0];
        result_next.green_out = outc[1];
        result_next.blue_out  = outc[2];
        result_next.alpha_out = ctl_in.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hdl/sepia_fade_brightness_pixel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepia_fade_brightness_pixel
// RGBA pixel filter: optional sepia mix and fade, then brightness offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive pixel and pulse start; a transaction is taken at
//   every rising edge with start high and busy low. busy is always low, so
//   one pixel can be issued every clock with no gaps.
//   Output channel: done is high for exactly one cycle with the filtered
//   pixel on result. The receiver has no back-pressure and must take it.
//   Throughput: one pixel per clock. done and result are registered in the
//   last pipeline stage, after the brightness add + clamp.
//   Pipeline: input register, sepia sums, divide by 1000 + clamp, fade
//   scaling, fade reciprocal divide + bias, brightness add + clamp. Each
//   stage holds at most one multiplier level; a valid bit travels with it.
//   Configuration: APB, vintage_enable at 0x0, brightness at 0x4. The
//   brightness offset is computed once on the write and travels with each
//   pixel. Reprogram only while the pipeline is empty.
//   Reset: rst_n clears all valid bits and loads vintage_enable = 0,
//   brightness = 50 (neutral); in-flight pixels are dropped.
// ----------------------------------------------------------------------------
module sepia_fade_brightness_pixel (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sfb_pkg::pixel_t                pixel,
    output logic                           done,
    output sfb_pkg::result_t               result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sfb_pkg::*;

    logic              vintage;
    logic signed [7:0] offset;
    ctl_t              in_reg;
    ctl_t              sep_ctl;
    ctl_t              fade_ctl;
    logic [7:0]        sep_r;
    logic [7:0]        sep_g;
    logic [7:0]        sep_b;
    logic [7:0]        fade_r;
    logic [7:0]        fade_g;
    logic [7:0]        fade_b;

    // Fully pipelined: never refuses a transaction
    assign busy = 1'b0;

    sfb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .vintage (vintage),
        .offset  (offset)
    );

    // Stage 1: capture pixel together with the active configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
        end
        else
        begin
            in_reg.valid   <= start & ~busy;
            in_reg.vintage <= vintage;
            in_reg.offset  <= offset;
            in_reg.red     <= pixel.red_in;
            in_reg.green   <= pixel.green_in;
            in_reg.blue    <= pixel.blue_in;
            in_reg.alpha   <= pixel.alpha_in;
        end
    end

    // Stages 2-3: sepia mix
    sfb_sepia u_sepia (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (in_reg),
        .ctl_out (sep_ctl),
        .sep_r   (sep_r),
        .sep_g   (sep_g),
        .sep_b   (sep_b)
    );

    // Stages 4-5: fade
    sfb_fade u_fade (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (sep_ctl),
        .sep_r   (sep_r),
        .sep_g   (sep_g),
        .sep_b   (sep_b),
        .ctl_out (fade_ctl),
        .fade_r  (fade_r),
        .fade_g  (fade_g),
        .fade_b  (fade_b)
    );

    // Stage 6: bypass select, brightness, output register
    sfb_bright u_bright (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (fade_ctl),
        .fade_r (fade_r),
        .fade_g (fade_g),
        .fade_b (fade_b),
        .done   (done),
        .result (result)
    );

endmodule
